FILE: src/bpk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpk_pkg;

  localparam int MaxFieldBits = 32;

  localparam logic [1:0] ReqUnsigned = 2'd0;
  localparam logic [1:0] ReqSigned   = 2'd1;
  localparam logic [1:0] ReqVariable = 2'd2;
  localparam logic [1:0] ReqFlush    = 2'd3;

  localparam logic [30:0] FieldMax = 31'h7FFF_FFFF;

  // one run of bits, first bit in bit 0
  typedef struct packed {
    logic [31:0] data;
    logic [5:0]  len;
  } seg_t;

  typedef struct packed {
    seg_t a;
    seg_t b;
  } segs_t;

  typedef struct packed {
    logic [7:0] pending;
    logic [2:0] bitpos;
    seg_t       seg;
    logic       full;
  } chunk_t;

endpackage

`default_nettype wire

FILE: src/bpk_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module bpk_prep import bpk_pkg::*; (
  input  wire logic [1:0]        req_type,
  input  wire logic signed [31:0] field_value,
  input  wire logic [5:0]        field_width,
  output segs_t                  segs
);

  always_comb begin
    logic [5:0]  wc;
    logic [30:0] maxv;
    logic [30:0] cap;
    logic [30:0] uval;
    logic [30:0] vval;
    logic [31:0] absv;
    logic [31:0] mag;
    logic [4:0]  blen;
    logic [4:0]  prefix;
    logic        neg;
    logic        sign;

    neg = field_value[31];
    wc = (field_width > 6'(MaxFieldBits)) ? 6'(MaxFieldBits) : field_width;
    maxv = (wc >= 6'd31) ? FieldMax : 31'((32'd1 << wc) - 32'd1);

    // unsigned clamp
    uval = neg ? 31'd0 : ((field_value[30:0] > maxv) ? maxv : field_value[30:0]);

    // signed clamp, sign is 1 for non-negative
    absv = neg ? (~field_value + 32'd1) : field_value;
    mag = (absv > {1'b0, maxv}) ? {1'b0, maxv} : absv;
    sign = !neg || (maxv == 31'd0);

    // variable clamp and bit length
    unique case (wc)
      6'd0: cap = 31'd1;
      6'd1: cap = 31'd3;
      6'd2: cap = 31'd15;
      6'd3: cap = 31'd255;
      6'd4: cap = 31'd65535;
      default: cap = FieldMax;
    endcase
    vval = neg ? 31'd0 : ((field_value[30:0] > cap) ? cap : field_value[30:0]);
    blen = 5'd1;
    for (int i = 0; i < 31; i++) begin
      if (vval[i]) begin
        blen = 5'(i + 1);
      end
    end
    prefix = ({26'd0, blen} > maxv) ? maxv[4:0] : blen;

    unique case (req_type)
      ReqUnsigned: begin
        segs.a = '{data: {1'b0, uval}, len: wc};
        segs.b = '0;
      end
      ReqSigned: begin
        segs.a = '{data: {31'd0, sign}, len: 6'd1};
        segs.b = '{data: mag, len: wc};
      end
      ReqVariable: begin
        segs.a = '{data: {27'd0, prefix}, len: wc};
        segs.b = '{data: {1'b0, vval}, len: {1'b0, blen}};
      end
      ReqFlush: begin
        segs = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/bpk_chunk.sv
`timescale 1ns / 1ps
`default_nettype none

module bpk_chunk import bpk_pkg::*; (
  input  wire logic [7:0] pending,
  input  wire logic [2:0] bitpos,
  input  wire seg_t       seg,
  output chunk_t          res
);

  always_comb begin
    logic [3:0] room;
    logic [3:0] take;
    logic [7:0] mask;
    logic [7:0] bits;
    logic [3:0] sum;

    room = 4'd8 - {1'b0, bitpos};
    take = (seg.len > {2'b0, room}) ? room : seg.len[3:0];
    mask = 8'((9'd1 << take) - 9'd1);
    bits = seg.data[7:0] & mask;
    sum = {1'b0, bitpos} + take;

    res.pending = pending | 8'(bits << bitpos);
    res.bitpos = sum[2:0];
    res.full = sum[3];
    res.seg.data = seg.data >> take;
    res.seg.len = seg.len - {2'b0, take};
  end

endmodule

`default_nettype wire

FILE: src/clamping_lsb_first_bit_packer_top.sv
// Clamping LSB-first bit packer.
// Input channel: in_valid / in_stall with req_type, field_value, field_width.
// A transfer happens at a rising edge with valid high and stall low. in_stall
// is high while an item is at work, so one item is taken at a time.
// Output channel: out_valid / out_stall with out_byte, last_in_run and
// end_of_message; one byte per transfer, first written bit in bit 0.
// Sequence: after the accept, a prep state clamps the value and forms up to
// two bit runs; a flush instead sends the pending byte from that state. Then
// the shared chunk shifter moves up to (8 - bit position) bits into the
// pending byte per cycle while the output register is free, one step per
// byte that each run touches. A byte is valid the cycle after the step that
// fills it.
// Each full byte goes to a single output register; the chunk shifter advances
// only when that register is empty or being taken, so a stalled receiver
// holds the packer in place and no byte is lost.
// Reset (rst, synchronous) clears the pending byte, the bit position, the
// sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module clamping_lsb_first_bit_packer_top import bpk_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] field_value,
  input  wire logic [5:0]         field_width,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_in_run,
  output logic                    end_of_message
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        req_type_q;
  logic signed [31:0] field_value_q;
  logic [5:0]        field_width_q;
  segs_t             segs;
  segs_t             prep_segs;
  logic [7:0]        pending;
  logic [2:0]        bitpos;

  logic   out_free;
  logic   use_a;
  seg_t   active;
  chunk_t res;
  logic [6:0] total;
  logic [6:0] remaining;
  logic   emit_byte;
  logic   flush_go;
  logic   in_xfer;

  bpk_prep u_prep (
    .req_type    (req_type_q),
    .field_value (field_value_q),
    .field_width (field_width_q),
    .segs        (prep_segs)
  );

  bpk_chunk u_chunk (
    .pending (pending),
    .bitpos  (bitpos),
    .seg     (active),
    .res     (res)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign use_a     = (segs.a.len != 6'd0);
  assign active    = use_a ? segs.a : segs.b;
  assign total     = 7'(segs.a.len) + 7'(segs.b.len);
  assign remaining = 7'(res.seg.len) + (use_a ? 7'(segs.b.len) : 7'd0);
  assign emit_byte = (state == ST_RUN) && (total != 7'd0) && out_free && res.full;
  assign flush_go  = (state == ST_PREP) && (req_type_q == ReqFlush) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pending   <= 8'd0;
      bitpos    <= 3'd0;
    end else begin
      if (emit_byte || flush_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (req_type_q == ReqFlush) begin
            if (out_free) begin
              pending <= 8'd0;
              bitpos  <= 3'd0;
              state   <= ST_IDLE;
            end
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (total == 7'd0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pending <= res.full ? 8'd0 : res.pending;
            bitpos  <= res.bitpos;
            if (remaining == 7'd0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_type_q    <= req_type;
      field_value_q <= field_value;
      field_width_q <= field_width;
    end
    if (state == ST_PREP) begin
      segs <= prep_segs;
    end else if ((state == ST_RUN) && (total != 7'd0) && out_free) begin
      if (use_a) begin
        segs.a <= res.seg;
      end else begin
        segs.b <= res.seg;
      end
    end
    if (emit_byte) begin
      out_byte       <= res.pending;
      last_in_run    <= (remaining < 7'd8);
      end_of_message <= 1'b0;
    end else if (flush_go) begin
      out_byte       <= pending;
      last_in_run    <= 1'b1;
      end_of_message <= 1'b1;
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_PREP) && in_stall)
    else $error("accepted item did not enter prep");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    flush_go |=> out_valid && end_of_message && last_in_run
                 && (pending == 8'd0) && (bitpos == 3'd0))
    else $error("flush did not emit and clear");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_in_run) |-> in_stall)
    else $error("non-last byte waiting while idle");

  a_progress: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && (total != 7'd0) && out_free) |=> (total < $past(total)))
    else $error("chunk shifter made no progress");

endmodule

`default_nettype wire
